// ===== sv/cdbt_pkg.sv =====
// Shared constants, codes and item types of the column duty/boost tracker.
`default_nettype none

package cdbt_pkg;

   // Default window depths
   localparam int DUTY_WINDOW_DEF    = 128;
   localparam int PATTERN_WINDOW_DEF = 32;

   // Fixed-point formats
   localparam int          DUTY_FRAC = 15;
   localparam logic [15:0] Q15_ONE   = 16'h8000;
   localparam logic [15:0] Q8_ONE    = 16'h0100;

   localparam logic signed [15:0] NO_PATTERN = -16'sd1;

   // Item op codes
   localparam logic [1:0] OP_OVERLAP = 2'd0;
   localparam logic [1:0] OP_STATE   = 2'd1;
   localparam logic [1:0] OP_BOOST   = 2'd2;

   // Control register port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_ACTIVATION = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOOST_START    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOOST_GAIN     = 2'd2;

   localparam logic [9:0]  MIN_ACTIVATION_RST = 10'd1;
   localparam logic [15:0] BOOST_START_RST    = 16'd0;
   localparam logic [15:0] BOOST_GAIN_RST     = 16'd256;

   typedef struct packed {
      logic [1:0]         op;
      logic [9:0]         raw_sum;
      logic               active;
      logic signed [15:0] pattern;
      logic [15:0]        min_duty;
   } req_item_type;

   typedef struct packed {
      logic [17:0]        boosted_sum;
      logic [15:0]        overlap_duty;
      logic [15:0]        active_duty;
      logic signed [15:0] likely_pattern;
      logic [15:0]        boost_value;
      logic               strengthen;
   } rsp_item_type;

   // Top level to pattern mode unit
   typedef struct packed {
      logic               start;
      logic signed [15:0] pattern;
   } mode_req_type;

   // Pattern mode unit to top level
   typedef struct packed {
      logic               done;
      logic signed [15:0] likely;
   } mode_rsp_type;

endpackage

`default_nettype wire

// ===== sv/cdbt_channels.sv =====
// Valid/ready channel interfaces for request and response items.
`default_nettype none

interface cdbt_req_if;
   import cdbt_pkg::*;

   logic         valid;
   logic         ready;
   req_item_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface cdbt_rsp_if;
   import cdbt_pkg::*;

   logic         valid;
   logic         ready;
   rsp_item_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/cdbt_serial_div.sv =====
// Restoring radix-2 divider: (ones << 15) / window, one quotient bit per cycle.
`default_nettype none

module cdbt_serial_div #(
   parameter int DEN_W = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DEN_W-1:0] ones,
   input  wire logic [DEN_W-1:0] denom,
   output logic                  done,
   output logic [15:0]           quotient
);
   import cdbt_pkg::*;

   localparam int NUM_W = DEN_W + DUTY_FRAC;
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   rem_sh, rem_diff;
   logic             ge;

   always_comb begin
      rem_sh   = {rem_ff, quo_ff[NUM_W-1]};
      rem_diff = rem_sh - {1'b0, den_ff};
      ge       = rem_sh >= {1'b0, den_ff};

      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;

      if (start) begin
         quo_in = {ones, {DUTY_FRAC{1'b0}}};
         rem_in = '0;
         den_in = denom;
         cnt_in = CNT_W'(NUM_W);
      end else if (cnt_ff != '0) begin
         quo_in  = {quo_ff[NUM_W-2:0], ge};
         // remainder stays below the divisor, so the top bit drops cleanly
         rem_in  = ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff[15:0];

endmodule

`default_nettype wire

// ===== sv/cdbt_pat_mode.sv =====
// Pattern history memory and pairwise-count mode finder (ties to smallest).
`default_nettype none

module cdbt_pat_mode #(
   parameter int PATTERN_WINDOW = cdbt_pkg::PATTERN_WINDOW_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire cdbt_pkg::mode_req_type                mode_req,
   input  wire logic [$clog2(PATTERN_WINDOW+1)-1:0]   mode_len,
   output cdbt_pkg::mode_rsp_type                     mode_rsp
);
   import cdbt_pkg::*;

   localparam int PAW = $clog2(PATTERN_WINDOW);
   localparam int MW  = $clog2(PATTERN_WINDOW + 1);

   typedef enum logic [5:0] {
      M_IDLE = 6'b000001,
      M_RDI  = 6'b000010,
      M_CAP  = 6'b000100,
      M_SCAN = 6'b001000,
      M_UPD  = 6'b010000,
      M_DONE = 6'b100000
   } mstate_type;

   mstate_type state_ff, state_in;

   logic signed [15:0]        pat_mem_ff [PATTERN_WINDOW];
   logic [PATTERN_WINDOW-1:0] pat_vld_ff;
   logic signed [15:0]        rd_data_ff;
   logic                      rd_vld_ff;
   logic [PAW-1:0]            rd_addr;
   logic signed [15:0]        rd_word;

   logic [PAW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [MW-1:0]      i_ff, i_in, j_ff, j_in, len_ff, len_in;
   logic [MW-1:0]      cnt_ff, cnt_in, best_cnt_ff, best_cnt_in;
   logic signed [15:0] cand_ff, cand_in, best_ff, best_in;
   logic               cmp_vld_ff, cmp_vld_in;
   logic               wr_en;

   assign wr_en   = (state_ff == M_IDLE) && mode_req.start;
   assign rd_word = rd_vld_ff ? rd_data_ff : NO_PATTERN;

   always_comb begin
      state_in    = state_ff;
      wr_ptr_in   = wr_ptr_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      len_in      = len_ff;
      cnt_in      = cnt_ff;
      best_cnt_in = best_cnt_ff;
      cand_in     = cand_ff;
      best_in     = best_ff;
      cmp_vld_in  = 1'b0;
      rd_addr     = '0;

      unique case (state_ff)
         M_IDLE: begin
            if (mode_req.start) begin
               wr_ptr_in   = (wr_ptr_ff == PAW'(PATTERN_WINDOW - 1)) ? '0 : wr_ptr_ff + 1'b1;
               i_in        = '0;
               len_in      = mode_len;
               best_in     = NO_PATTERN;
               best_cnt_in = '0;
               state_in    = (mode_len == '0) ? M_DONE : M_RDI;
            end
         end
         M_RDI: begin
            rd_addr  = i_ff[PAW-1:0];
            state_in = M_CAP;
         end
         M_CAP: begin
            cand_in  = rd_word;
            j_in     = '0;
            cnt_in   = '0;
            state_in = M_SCAN;
         end
         M_SCAN: begin
            // read j issued here, compared in the next cycle
            rd_addr = j_ff[PAW-1:0];
            if (j_ff < len_ff) begin
               j_in       = j_ff + 1'b1;
               cmp_vld_in = 1'b1;
            end
            if (cmp_vld_ff && (rd_word == cand_ff)) begin
               cnt_in = cnt_ff + 1'b1;
            end
            if ((j_ff >= len_ff) && !cmp_vld_ff) begin
               state_in = M_UPD;
            end
         end
         M_UPD: begin
            if ((cnt_ff > best_cnt_ff) || ((cnt_ff == best_cnt_ff) && (cand_ff < best_ff))) begin
               best_in     = cand_ff;
               best_cnt_in = cnt_ff;
            end
            i_in     = i_ff + 1'b1;
            state_in = (i_in == len_ff) ? M_DONE : M_RDI;
         end
         M_DONE: begin
            state_in = M_IDLE;
         end
         default: begin
            state_in = M_IDLE;
         end
      endcase
   end

   // history memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         pat_mem_ff[wr_ptr_ff] <= mode_req.pattern;
      end
      rd_data_ff <= pat_mem_ff[rd_addr];
      rd_vld_ff  <= pat_vld_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= M_IDLE;
         pat_vld_ff <= '0;
         wr_ptr_ff  <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         wr_ptr_ff  <= wr_ptr_in;
         cmp_vld_ff <= cmp_vld_in;
         if (wr_en) begin
            pat_vld_ff[wr_ptr_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      j_ff        <= j_in;
      len_ff      <= len_in;
      cnt_ff      <= cnt_in;
      best_cnt_ff <= best_cnt_in;
      cand_ff     <= cand_in;
      best_ff     <= best_in;
   end

   assign mode_rsp.done   = (state_ff == M_DONE);
   assign mode_rsp.likely = best_ff;

endmodule

`default_nettype wire

// ===== sv/column_duty_boost_tracker_core.sv =====
// Top level of the column duty-cycle and boost tracker.
`default_nettype none

// Per-column bookkeeping for a spatial-pooler column, one item at a time.
// An overlap item (op 0) thresholds the raw sum against min_activation, counts
// the step, logs overlap in a bit ring, recomputes the overlap duty and returns
// the sum times the Q8.8 boost. A state item (op 1) logs activity, recomputes
// the active duty and, when active, stores the pattern index and finds the most
// frequent recent index (ties go to the smallest). A boost item (op 2) sets the
// boost from the active-duty shortfall and flags strengthening when the overlap
// duty is below min_duty. Op 3 changes nothing. Duties are Q1.15, boost Q8.8.
// Flow: one item at a time; req ready is high only in idle. Op 3 goes straight
// to the result and a boost item through the multiply. A duty update scans the
// ring one bit a cycle through a registered read, then, for nonzero n =
// min(DUTY_WINDOW, steps), runs the serial divider (CW bits hold DUTY_WINDOW);
// an empty window keeps the old duty. An overlap item then goes through the
// multiply and output, an inactive state item to output, and an active state
// item runs the pattern mode unit over the last m = min(PATTERN_WINDOW,
// activations) patterns.
// A finished item sits in the output register, so the next item may be
// accepted while it waits. No clearing pass after reset: the active ring keeps
// a fill count so entries not yet written read as zero; the overlap scan only
// ever reaches written entries.
module column_duty_boost_tracker_core #(
   parameter int DUTY_WINDOW    = cdbt_pkg::DUTY_WINDOW_DEF,
   parameter int PATTERN_WINDOW = cdbt_pkg::PATTERN_WINDOW_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   cdbt_req_if.sink                              req_chan,
   cdbt_rsp_if.source                            rsp_chan,
   input  wire logic                             csr_wr_en,
   input  wire logic [cdbt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [cdbt_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import cdbt_pkg::*;

   localparam int CW = $clog2(DUTY_WINDOW + 1);    // ones / window count
   localparam int AW = $clog2(DUTY_WINDOW);        // ring index
   localparam int MW = $clog2(PATTERN_WINDOW + 1); // pattern window length

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_SCAN = 7'b0000010,
      S_DIV  = 7'b0000100,
      S_MODE = 7'b0001000,
      S_MUL  = 7'b0010000,
      S_FIN  = 7'b0100000,
      S_DONE = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // control registers
   logic [9:0]  min_act_ff, min_act_in;
   logic [15:0] boost_start_ff, boost_start_in;
   logic [15:0] boost_gain_ff, boost_gain_in;

   // column state
   logic                   overlap_mem_ff [DUTY_WINDOW];
   logic                   active_mem_ff  [DUTY_WINDOW];
   logic [CW-1:0]          act_fill_ff, act_fill_in;
   logic [AW-1:0]          overlap_ptr_ff, overlap_ptr_in;
   logic [AW-1:0]          active_ptr_ff, active_ptr_in;
   logic [31:0]            step_count_ff, step_count_in;
   logic [31:0]            active_count_ff, active_count_in;
   logic [15:0]            boost_ff, boost_in;
   logic [15:0]            active_duty_ff, active_duty_in;
   logic [15:0]            overlap_duty_ff, overlap_duty_in;
   logic signed [15:0]     likely_ff, likely_in;

   // item in flight
   logic [1:0]         op_ff, op_in;
   logic [9:0]         raw_ff, raw_in;
   logic               act_ff, act_in;
   logic signed [15:0] pattern_ff, pattern_in;
   logic [15:0]        min_duty_ff, min_duty_in;
   logic [CW-1:0]      scan_idx_ff, scan_idx_in;
   logic               scan_vld_ff, scan_vld_in;
   logic [CW-1:0]      ones_ff, ones_in;
   logic [31:0]        product_ff, product_in;
   logic [17:0]        boosted_ff, boosted_in;
   logic               strengthen_ff, strengthen_in;

   // ring read port
   logic [AW-1:0] rd_idx;
   logic          ovl_rd_ff, act_rd_ff, act_ok_ff;
   logic          ovl_we, act_we;

   // output register
   rsp_item_type rsp_data_ff, rsp_data_in;
   logic         rsp_valid_ff, rsp_valid_in;

   // datapath
   logic [9:0]   raw_thr;
   logic [CW-1:0] n_win;
   logic [MW-1:0] m_win;
   logic         ring_bit;
   logic [15:0]  mul_a, mul_b;
   logic [31:0]  mul_prod;
   logic [17:0]  boost_sum;
   logic [15:0]  boost_sat;
   logic         boost_hold;
   logic         duty_end;
   logic         div_start, div_done;
   logic [15:0]  div_quot;
   mode_req_type mode_req;
   mode_rsp_type mode_rsp;
   logic         req_acc;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_acc        = req_chan.valid && req_chan.ready;
   assign ovl_we         = req_acc && (req_chan.data.op == OP_OVERLAP);
   assign act_we         = req_acc && (req_chan.data.op == OP_STATE);

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   always_comb begin
      raw_thr = (req_chan.data.raw_sum < min_act_ff) ? '0 : req_chan.data.raw_sum;

      // window sizes track the counters, clamped to the ring depth
      n_win = (step_count_ff >= 32'(DUTY_WINDOW)) ? CW'(DUTY_WINDOW) : step_count_ff[CW-1:0];
      m_win = (active_count_ff >= 32'(PATTERN_WINDOW)) ?
              MW'(PATTERN_WINDOW) : active_count_ff[MW-1:0];

      rd_idx   = (scan_idx_ff < n_win) ? scan_idx_ff[AW-1:0] : '0;
      ring_bit = (op_ff == OP_OVERLAP) ? ovl_rd_ff : (act_rd_ff && act_ok_ff);

      // one shared multiplier: sum * boost, or shortfall * gain
      mul_a    = (op_ff == OP_OVERLAP) ? {6'b0, raw_ff} : (min_duty_ff - active_duty_ff);
      mul_b    = (op_ff == OP_OVERLAP) ? boost_ff : boost_gain_ff;
      mul_prod = mul_a * mul_b;

      boost_sum  = {1'b0, product_ff[31:15]} + {2'b0, Q8_ONE};
      boost_sat  = (boost_sum > 18'h0FFFF) ? 16'hFFFF : boost_sum[15:0];
      boost_hold = (step_count_ff < {16'b0, boost_start_ff}) || (active_duty_ff > min_duty_ff);
   end

   always_comb begin
      state_in        = state_ff;
      min_act_in      = min_act_ff;
      boost_start_in  = boost_start_ff;
      boost_gain_in   = boost_gain_ff;
      act_fill_in     = act_fill_ff;
      overlap_ptr_in  = overlap_ptr_ff;
      active_ptr_in   = active_ptr_ff;
      step_count_in   = step_count_ff;
      active_count_in = active_count_ff;
      boost_in        = boost_ff;
      active_duty_in  = active_duty_ff;
      overlap_duty_in = overlap_duty_ff;
      likely_in       = likely_ff;
      op_in           = op_ff;
      raw_in          = raw_ff;
      act_in          = act_ff;
      pattern_in      = pattern_ff;
      min_duty_in     = min_duty_ff;
      scan_idx_in     = scan_idx_ff;
      scan_vld_in     = 1'b0;
      ones_in         = ones_ff;
      product_in      = product_ff;
      boosted_in      = boosted_ff;
      strengthen_in   = strengthen_ff;
      rsp_data_in     = rsp_data_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      div_start       = 1'b0;
      duty_end        = 1'b0;
      mode_req.start   = 1'b0;
      mode_req.pattern = pattern_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MIN_ACTIVATION: min_act_in     = csr_wdata[9:0];
            CSR_BOOST_START:    boost_start_in = csr_wdata;
            CSR_BOOST_GAIN:     boost_gain_in  = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               op_in         = req_chan.data.op;
               raw_in        = raw_thr;
               act_in        = req_chan.data.active;
               pattern_in    = req_chan.data.pattern;
               min_duty_in   = req_chan.data.min_duty;
               scan_idx_in   = '0;
               ones_in       = '0;
               boosted_in    = '0;
               strengthen_in = (req_chan.data.op == OP_BOOST) &&
                               (overlap_duty_ff < req_chan.data.min_duty);
               unique case (req_chan.data.op)
                  OP_OVERLAP: begin
                     step_count_in  = step_count_ff + 1'b1;
                     overlap_ptr_in = (overlap_ptr_ff == AW'(DUTY_WINDOW - 1)) ?
                                      '0 : overlap_ptr_ff + 1'b1;
                     state_in = S_SCAN;
                  end
                  OP_STATE: begin
                     active_ptr_in = (active_ptr_ff == AW'(DUTY_WINDOW - 1)) ?
                                     '0 : active_ptr_ff + 1'b1;
                     act_fill_in   = (act_fill_ff == CW'(DUTY_WINDOW)) ?
                                     act_fill_ff : act_fill_ff + 1'b1;
                     if (req_chan.data.active) begin
                        active_count_in = active_count_ff + 1'b1;
                     end
                     state_in = S_SCAN;
                  end
                  OP_BOOST: state_in = S_MUL;
                  default:  state_in = S_DONE;
               endcase
            end
         end
         S_SCAN: begin
            // count ones in ring entries 0..n-1; read issued here, summed in the next cycle
            if (scan_idx_ff < n_win) begin
               scan_idx_in = scan_idx_ff + 1'b1;
               scan_vld_in = 1'b1;
            end
            if (scan_vld_ff) begin
               ones_in = ones_ff + CW'(ring_bit);
            end
            if ((scan_idx_ff >= n_win) && !scan_vld_ff) begin
               if (n_win == '0) begin
                  duty_end = 1'b1;   // empty window keeps the old duty
               end else begin
                  div_start = 1'b1;
                  state_in  = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               if (op_ff == OP_OVERLAP) begin
                  overlap_duty_in = div_quot;
               end else begin
                  active_duty_in = div_quot;
               end
               duty_end = 1'b1;
            end
         end
         S_MODE: begin
            if (mode_rsp.done) begin
               likely_in = mode_rsp.likely;
               state_in  = S_DONE;
            end
         end
         S_MUL: begin
            product_in = mul_prod;
            state_in   = S_FIN;
         end
         S_FIN: begin
            if (op_ff == OP_OVERLAP) begin
               boosted_in = product_ff[25:8];
            end else begin
               boost_in = boost_hold ? Q8_ONE : boost_sat;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_data_in.boosted_sum    = boosted_ff;
               rsp_data_in.overlap_duty   = overlap_duty_ff;
               rsp_data_in.active_duty    = active_duty_ff;
               rsp_data_in.likely_pattern = likely_ff;
               rsp_data_in.boost_value    = boost_ff;
               rsp_data_in.strengthen     = strengthen_ff;
               rsp_valid_in               = 1'b1;
               state_in                   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // after the duty update: overlap goes to the multiply, an active
      // state item to the pattern mode search, an inactive one to done
      if (duty_end) begin
         if (op_ff == OP_OVERLAP) begin
            state_in = S_MUL;
         end else if (act_ff) begin
            mode_req.start = 1'b1;
            state_in       = S_MODE;
         end else begin
            state_in = S_DONE;
         end
      end
   end

   // history rings: one write at accept, one registered read a cycle
   always_ff @(posedge clock) begin
      if (ovl_we) begin
         overlap_mem_ff[overlap_ptr_ff] <= (raw_thr != '0);
      end
      if (act_we) begin
         active_mem_ff[active_ptr_ff] <= req_chan.data.active;
      end
      ovl_rd_ff <= overlap_mem_ff[rd_idx];
      act_rd_ff <= active_mem_ff[rd_idx];
      act_ok_ff <= (scan_idx_ff < act_fill_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         min_act_ff      <= MIN_ACTIVATION_RST;
         boost_start_ff  <= BOOST_START_RST;
         boost_gain_ff   <= BOOST_GAIN_RST;
         act_fill_ff     <= '0;
         overlap_ptr_ff  <= '0;
         active_ptr_ff   <= '0;
         step_count_ff   <= '0;
         active_count_ff <= '0;
         boost_ff        <= Q8_ONE;
         active_duty_ff  <= Q15_ONE;
         overlap_duty_ff <= Q15_ONE;
         likely_ff       <= NO_PATTERN;
         scan_vld_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         min_act_ff      <= min_act_in;
         boost_start_ff  <= boost_start_in;
         boost_gain_ff   <= boost_gain_in;
         act_fill_ff     <= act_fill_in;
         overlap_ptr_ff  <= overlap_ptr_in;
         active_ptr_ff   <= active_ptr_in;
         step_count_ff   <= step_count_in;
         active_count_ff <= active_count_in;
         boost_ff        <= boost_in;
         active_duty_ff  <= active_duty_in;
         overlap_duty_ff <= overlap_duty_in;
         likely_ff       <= likely_in;
         scan_vld_ff     <= scan_vld_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      raw_ff        <= raw_in;
      act_ff        <= act_in;
      pattern_ff    <= pattern_in;
      min_duty_ff   <= min_duty_in;
      scan_idx_ff   <= scan_idx_in;
      ones_ff       <= ones_in;
      product_ff    <= product_in;
      boosted_ff    <= boosted_in;
      strengthen_ff <= strengthen_in;
      rsp_data_ff   <= rsp_data_in;
   end

   cdbt_serial_div #(
      .DEN_W (CW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .ones     (ones_ff),
      .denom    (n_win),
      .done     (div_done),
      .quotient (div_quot)
   );

   cdbt_pat_mode #(
      .PATTERN_WINDOW (PATTERN_WINDOW)
   ) u_mode (
      .clock    (clock),
      .reset    (reset),
      .mode_req (mode_req),
      .mode_len (m_win),
      .mode_rsp (mode_rsp)
   );

endmodule

`default_nettype wire
